### design/lltuv_pkg.sv
package lltuv_pkg;

    // Field widths
    localparam int LON_W = 25;
    localparam int LAT_W = 24;
    localparam int OUT_W = 18;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    // CORDIC datapath: angles in degrees Q24, x/y in Q30
    localparam int ANG_W  = 32;
    localparam int XY_W   = 32;
    localparam int PROD_W = 2 * XY_W;
    localparam int MAX_STEPS = 32;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // Clamp bounds, degrees Q16
    localparam logic signed [LON_W-1:0] LON_HALF_TURN = 25'sd11796480;
    localparam logic signed [LON_W-1:0] LON_QUARTER   = 25'sd5898240;
    localparam logic signed [LAT_W-1:0] LAT_QUARTER   = 24'sd5898240;

    // Unit value of the outputs
    localparam int ONE_OUT = 65536;

    // atan(2^-i) in degrees, Q24, round to nearest
    localparam logic signed [ANG_W-1:0] ATAN_DEG_Q24 [MAX_STEPS] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115,
        32'sd57,        32'sd29,        32'sd14,        32'sd7,
        32'sd4,         32'sd2,         32'sd1,         32'sd0
    };

endpackage

### design/lltuv_cordic_step.sv
module lltuv_cordic_step #(
    parameter int STEP = 0
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [lltuv_pkg::XY_W-1:0]    x_in,
    input  logic signed [lltuv_pkg::XY_W-1:0]    y_in,
    input  logic signed [lltuv_pkg::ANG_W-1:0]   z_in,
    output logic signed [lltuv_pkg::XY_W-1:0]    x_out_reg,
    output logic signed [lltuv_pkg::XY_W-1:0]    y_out_reg,
    output logic signed [lltuv_pkg::ANG_W-1:0]   z_out_reg
);
    import lltuv_pkg::*;

    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic signed [XY_W-1:0]  x_next;
    logic signed [XY_W-1:0]  y_next;
    logic signed [ANG_W-1:0] z_next;

    // floor shifts of the old values
    assign dx = y_in >>> STEP;
    assign dy = x_in >>> STEP;

    always_comb
    begin
        if (!z_in[ANG_W-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN_DEG_Q24[STEP];
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN_DEG_Q24[STEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_out_reg <= x_next;
            y_out_reg <= y_next;
            z_out_reg <= z_next;
        end
    end

endmodule

### design/lonlat_to_unit_vector_unit.sv
// Longitude/latitude (degrees, Q16) to a point on the unit sphere:
// x = cos(lon)cos(lat), y = sin(lon)cos(lat), z = sin(lat), each Q16 signed
// (1.0 = 65536), rounded half up and saturated to [-65536, 65536]. Inputs
// beyond +-180 / +-90 degrees are clamped. Longitudes beyond +-90 degrees
// are folded by a half turn and the sign of x and y is flipped. Sine and cosine
// come from two parallel CORDIC lanes (one for longitude, one for latitude)
// that work directly in degrees, one CORDIC step per register stage. One beat
// is accepted per cycle. The pipe holds an input
// clamp/fold stage, one stage per CORDIC step, a 32x32 multiply stage and a
// round/saturate output stage. The whole pipe moves together and holds when
// the output beat is not taken.
module lonlat_to_unit_vector_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [24:0] longitude, [48:25] latitude, [55:49] zero
    input  logic [lltuv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [17:0] coord_x, [35:18] coord_y, [53:36] coord_z, [55:54] zero
    output logic [lltuv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import lltuv_pkg::*;

    localparam int NSTEP  = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int NSTAGE = NSTEP + 3;
    localparam int MUL_ST = NSTEP + 1;

    // handshake: whole pipe advances unless output is stalled
    logic adv;
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;

    assign adv           = !valid_reg[NSTAGE-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = valid_reg[NSTAGE-1];
    assign valid_next    = {valid_reg[NSTAGE-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= valid_next;
    end

    // ---------------- stage 0: clamp and fold ----------------
    logic signed [LON_W-1:0] lon_in;
    logic signed [LAT_W-1:0] lat_in;
    logic signed [LON_W-1:0] lon_c;
    logic signed [LON_W-1:0] lon_f;
    logic signed [LAT_W-1:0] lat_c;
    logic                    flip_in;

    assign lon_in = s_axis_tdata[LON_W-1:0];
    assign lat_in = s_axis_tdata[LON_W+LAT_W-1:LON_W];

    always_comb
    begin
        priority if (lon_in > LON_HALF_TURN)
            lon_c = LON_HALF_TURN;
        else if (lon_in < -LON_HALF_TURN)
            lon_c = -LON_HALF_TURN;
        else
            lon_c = lon_in;

        priority if (lat_in > LAT_QUARTER)
            lat_c = LAT_QUARTER;
        else if (lat_in < -LAT_QUARTER)
            lat_c = -LAT_QUARTER;
        else
            lat_c = lat_in;

        // beyond a quarter turn: rotate by a half turn, negate cos and sin
        priority if (lon_c > LON_QUARTER)
        begin
            lon_f   = lon_c - LON_HALF_TURN;
            flip_in = 1'b1;
        end
        else if (lon_c < -LON_QUARTER)
        begin
            lon_f   = lon_c + LON_HALF_TURN;
            flip_in = 1'b1;
        end
        else
        begin
            lon_f   = lon_c;
            flip_in = 1'b0;
        end
    end

    logic signed [XY_W-1:0]  lon_x [0:NSTEP];
    logic signed [XY_W-1:0]  lon_y [0:NSTEP];
    logic signed [ANG_W-1:0] lon_z [0:NSTEP];
    logic signed [XY_W-1:0]  lat_x [0:NSTEP];
    logic signed [XY_W-1:0]  lat_y [0:NSTEP];
    logic signed [ANG_W-1:0] lat_z [0:NSTEP];

    logic signed [ANG_W-1:0] lon_ang_reg;
    logic signed [ANG_W-1:0] lat_ang_reg;
    logic [MUL_ST:0]         flip_reg;

    // Q16 -> Q24; folded values fit in 24 bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lon_ang_reg <= {lon_f[LAT_W-1:0], 8'd0};
            lat_ang_reg <= {lat_c, 8'd0};
            flip_reg    <= {flip_reg[MUL_ST-1:0], flip_in};
        end
    end

    assign lon_x[0] = CORDIC_GAIN_Q30;
    assign lon_y[0] = '0;
    assign lon_z[0] = lon_ang_reg;
    assign lat_x[0] = CORDIC_GAIN_Q30;
    assign lat_y[0] = '0;
    assign lat_z[0] = lat_ang_reg;

    // ---------------- CORDIC stages ----------------
    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        lltuv_cordic_step #(.STEP(i)) u_lon (
            .clk       (clk),
            .en        (adv),
            .x_in      (lon_x[i]),
            .y_in      (lon_y[i]),
            .z_in      (lon_z[i]),
            .x_out_reg (lon_x[i+1]),
            .y_out_reg (lon_y[i+1]),
            .z_out_reg (lon_z[i+1])
        );
        lltuv_cordic_step #(.STEP(i)) u_lat (
            .clk       (clk),
            .en        (adv),
            .x_in      (lat_x[i]),
            .y_in      (lat_y[i]),
            .z_in      (lat_z[i]),
            .x_out_reg (lat_x[i+1]),
            .y_out_reg (lat_y[i+1]),
            .z_out_reg (lat_z[i+1])
        );
    end

    // ---------------- multiply stage ----------------
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [XY_W-1:0]   slat_reg;
    logic                     res_lon_z_unused;

    // residual angles after the last step carry no result
    assign res_lon_z_unused = lon_z[NSTEP][0] ^ lat_z[NSTEP][0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_x_reg <= lon_x[NSTEP] * lat_x[NSTEP];
            prod_y_reg <= lon_y[NSTEP] * lat_x[NSTEP];
            slat_reg   <= lat_y[NSTEP];
        end
    end

    // ---------------- round / saturate stage ----------------
    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] v,
        input int                       sh
    );
        logic signed [PROD_W-1:0] r;
        logic signed [PROD_W-1:0] one_hi;
        logic signed [PROD_W-1:0] one_lo;
        begin
            one_hi = PROD_W'(ONE_OUT);
            one_lo = -one_hi;
            r = (v + (PROD_W'(1) <<< (sh - 1))) >>> sh;
            priority if (r > one_hi)
                r = one_hi;
            else if (r < one_lo)
                r = one_lo;
            round_sat = r[OUT_W-1:0];
        end
    endfunction

    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;
    logic signed [PROD_W-1:0] pz;
    logic signed [OUT_W-1:0]  coord_x_reg;
    logic signed [OUT_W-1:0]  coord_y_reg;
    logic signed [OUT_W-1:0]  coord_z_reg;

    // negating the product equals negating cos(lon) and sin(lon)
    assign px = flip_reg[MUL_ST] ? -prod_x_reg : prod_x_reg;
    assign py = flip_reg[MUL_ST] ? -prod_y_reg : prod_y_reg;
    assign pz = PROD_W'(slat_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            coord_x_reg <= round_sat(px, 44);
            coord_y_reg <= round_sat(py, 44);
            coord_z_reg <= round_sat(pz, 14);
        end
    end

    assign m_axis_tdata = {1'b0, res_lon_z_unused & 1'b0,
                           coord_z_reg, coord_y_reg, coord_x_reg};

`ifndef NO_ASSERTIONS
    // a stalled output beat freezes the whole pipe, including the input side
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // an accepted input beat occupies the first stage next cycle
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted beat missing from stage 0");

    // folded longitude stays within a quarter turn (Q24)
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> (lon_ang_reg <= 32'sd1509949440 && lon_ang_reg >= -32'sd1509949440))
        else $error("folded longitude out of range");

    // results saturated to the unit range
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (coord_x_reg <= 18'sd65536 && coord_x_reg >= -18'sd65536
                        && coord_y_reg <= 18'sd65536 && coord_y_reg >= -18'sd65536
                        && coord_z_reg <= 18'sd65536 && coord_z_reg >= -18'sd65536))
        else $error("coordinate out of unit range");
`endif

endmodule
